// File: src/decode_vote_confirm_assert.svh
// Assertion macros for the decode_vote_confirm RTL; the datapath includes them.
// The macros expect signals named clk and rst in the scope where they are used.
`ifndef DECODE_VOTE_CONFIRM_ASSERT_SVH
`define DECODE_VOTE_CONFIRM_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, disabled while reset is high.
`define DVC_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("decode_vote_confirm: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define DVC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("decode_vote_confirm: assertion failed");

`else

`define DVC_ASSERT_IMPL(label, ante, cons)
`define DVC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: src/dvc_pkg.sv
// Shared types and constants for the symbol vote confirmation block.
// No dependencies; used by the controller, the datapath and the top level.
`default_nettype none

package dvc_pkg;

  // Fixed field widths.
  localparam int CHAR_W = 8;
  localparam int POS_W  = 6;

  // Character position saturates here.
  localparam logic [POS_W-1:0] POS_MAX = 6'd63;

  // Line terminator appended to a confirmed symbol.
  localparam logic [CHAR_W-1:0] CHAR_CR = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_LF = 8'd10;

  // Outcome reported for every ended symbol.
  typedef enum logic [1:0] {
    VERDICT_STORED    = 2'd0,
    VERDICT_CONFIRMED = 2'd1,
    VERDICT_PARTIAL   = 2'd2,
    VERDICT_TOO_LONG  = 2'd3
  } verdict_t;

  // Source of the character loaded into the output register.
  typedef enum logic [1:0] {
    OUT_BLANK = 2'd0,
    OUT_CHAR  = 2'd1,
    OUT_CR    = 2'd2,
    OUT_LF    = 2'd3
  } out_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     take;
    logic     compare;
    logic     decide;
    logic     hist_write;
    logic     cursor_inc;
    logic     store_done;
    logic     out_load;
    out_sel_t out_sel;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic     last;
    verdict_t verdict;
    logic     cursor_done;
    logic     out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// File: src/dvc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module dvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// File: src/dvc_ctrl.sv
// Controller state machine for the symbol vote confirmation block.
// Depends on dvc_pkg for the command and status structs.
`default_nettype none

module dvc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dvc_pkg::dp_status_t status,
  output dvc_pkg::dp_cmd_t    cmd
);

  typedef enum logic [8:0] {
    ST_IDLE    = 9'b000000001,
    ST_COMPARE = 9'b000000010,
    ST_DECIDE  = 9'b000000100,
    ST_COPY_RD = 9'b000001000,
    ST_COPY_WR = 9'b000010000,
    ST_REPORT  = 9'b000100000,
    ST_EMIT_RD = 9'b001000000,
    ST_EMIT_CH = 9'b010000000,
    ST_EMIT_CR = 9'b100000000
  } state_t;

  // The line feed closes a confirmed run; it reuses the report path.
  state_t state;
  state_t state_next;
  logic   emit_lf;
  logic   emit_lf_next;

  // Nothing is accepted while reset is held.
  assign in_ready = (state == ST_IDLE) && !rst;

  // Next state and command decode.
  always_comb begin
    state_next   = state;
    emit_lf_next = emit_lf;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && in_ready) begin
          cmd.take   = 1'b1;
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: begin
        cmd.compare = 1'b1;
        state_next  = status.last ? ST_DECIDE : ST_IDLE;
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        unique case (status.verdict)
          dvc_pkg::VERDICT_STORED:    state_next = ST_COPY_RD;
          dvc_pkg::VERDICT_CONFIRMED: state_next = ST_EMIT_RD;
          default:                    state_next = ST_REPORT;
        endcase
      end
      ST_COPY_RD: begin
        if (status.cursor_done) begin
          cmd.store_done = 1'b1;
          state_next     = ST_REPORT;
        end else begin
          state_next = ST_COPY_WR;
        end
      end
      ST_COPY_WR: begin
        cmd.hist_write = 1'b1;
        cmd.cursor_inc = 1'b1;
        state_next     = ST_COPY_RD;
      end
      ST_REPORT: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = emit_lf ? dvc_pkg::OUT_LF : dvc_pkg::OUT_BLANK;
          emit_lf_next = 1'b0;
          state_next   = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        state_next = status.cursor_done ? ST_EMIT_CR : ST_EMIT_CH;
      end
      ST_EMIT_CH: begin
        if (status.out_free) begin
          cmd.out_load   = 1'b1;
          cmd.out_sel    = dvc_pkg::OUT_CHAR;
          cmd.cursor_inc = 1'b1;
          state_next     = ST_EMIT_RD;
        end
      end
      ST_EMIT_CR: begin
        if (status.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_sel  = dvc_pkg::OUT_CR;
          emit_lf_next = 1'b1;
          state_next   = ST_REPORT;
        end
      end
      default: begin
        state_next   = ST_IDLE;
        emit_lf_next = 1'b0;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      emit_lf <= 1'b0;
    end else begin
      state   <= state_next;
      emit_lf <= emit_lf_next;
    end
  end

endmodule

`default_nettype wire

// File: src/dvc_datapath.sv
// Datapath: staging buffer, per-slot history RAMs, vote logic and output register.
// Depends on dvc_pkg, dvc_ram and decode_vote_confirm_assert.svh.
`default_nettype none

`include "decode_vote_confirm_assert.svh"

module dvc_datapath #(
  parameter int SLOTS            = 8,
  parameter int MAX_SYMBOL_CHARS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  dvc_pkg::dp_cmd_t    cmd,
  output dvc_pkg::dp_status_t status,
  input  logic [7:0]          symbol_char,
  input  logic                char_last,
  input  logic                symbol_complete,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_char,
  output logic                out_last,
  output logic [1:0]          verdict,
  output logic [5:0]          symbol_length
);

  localparam int AW    = (MAX_SYMBOL_CHARS > 1) ? $clog2(MAX_SYMBOL_CHARS) : 1;
  localparam int SW    = $clog2(SLOTS);
  localparam int FW    = $clog2(SLOTS + 1);
  localparam int NEED  = SLOTS / 2;
  localparam int POS_W = dvc_pkg::POS_W;
  localparam int CW    = dvc_pkg::CHAR_W;
  localparam logic [POS_W-1:0] MAX_POS = POS_W'(MAX_SYMBOL_CHARS);

  // Symbol being assembled.
  logic [CW-1:0]    ch_reg;
  logic             last_reg;
  logic             complete_reg;
  logic [POS_W-1:0] char_position;
  logic [SLOTS-1:0] match_flags;
  logic             overlong;

  // History bookkeeping; written length per slot stands in for a clearing pass.
  logic [SW-1:0]    write_slot;
  logic [FW-1:0]    fill_count;
  logic [POS_W-1:0] slot_len [SLOTS];

  // Ended symbol and read cursor.
  dvc_pkg::verdict_t verdict_reg;
  logic [POS_W-1:0]  sym_len;
  logic [POS_W-1:0]  cursor;

  // Memory read data.
  logic [CW-1:0] stage_rd;
  logic [CW-1:0] slot_rd [SLOTS];

  // Combinational vote results.
  logic [SLOTS-1:0]  flags_cmp;
  logic [SLOTS-1:0]  filled;
  logic [FW-1:0]     votes;
  dvc_pkg::verdict_t verdict_next;
  logic [CW-1:0]     out_char_next;
  logic              in_range;

  assign in_range = (char_position < MAX_POS);

  // Staging buffer: written at the character position, read at the cursor.
  dvc_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_SYMBOL_CHARS)
  ) u_stage_ram (
    .clk   (clk),
    .we    (cmd.take && in_range),
    .waddr (char_position[AW-1:0]),
    .wdata (symbol_char),
    .raddr (cursor[AW-1:0]),
    .rdata (stage_rd)
  );

  // One history RAM per slot, all read at the current character position.
  for (genvar s = 0; s < SLOTS; s++) begin : g_slot
    dvc_ram #(
      .WIDTH (CW),
      .DEPTH (MAX_SYMBOL_CHARS)
    ) u_slot_ram (
      .clk   (clk),
      .we    (cmd.hist_write && (write_slot == SW'(s))),
      .waddr (cursor[AW-1:0]),
      .wdata (stage_rd),
      .raddr (char_position[AW-1:0]),
      .rdata (slot_rd[s])
    );
  end

  // Per-slot compare; bytes beyond a slot's written length read as zero.
  always_comb begin
    logic [CW-1:0] hist_byte;
    flags_cmp = match_flags;
    for (int s = 0; s < SLOTS; s++) begin
      hist_byte = (char_position < slot_len[s]) ? slot_rd[s] : '0;
      if (hist_byte != ch_reg) begin
        flags_cmp[s] = 1'b0;
      end
    end
  end

  // Vote over filled slots and the verdict for the ended symbol.
  always_comb begin
    for (int s = 0; s < SLOTS; s++) begin
      filled[s] = (FW'(s) < fill_count);
    end
    votes = FW'($countones(match_flags & filled));
    priority if (!complete_reg) begin
      verdict_next = dvc_pkg::VERDICT_PARTIAL;
    end else if (overlong) begin
      verdict_next = dvc_pkg::VERDICT_TOO_LONG;
    end else if ((fill_count >= FW'(NEED)) && (votes >= FW'(NEED))) begin
      verdict_next = dvc_pkg::VERDICT_CONFIRMED;
    end else begin
      verdict_next = dvc_pkg::VERDICT_STORED;
    end
  end

  // Output character selection.
  always_comb begin
    unique case (cmd.out_sel)
      dvc_pkg::OUT_BLANK: out_char_next = '0;
      dvc_pkg::OUT_CHAR:  out_char_next = stage_rd;
      dvc_pkg::OUT_CR:    out_char_next = dvc_pkg::CHAR_CR;
      dvc_pkg::OUT_LF:    out_char_next = dvc_pkg::CHAR_LF;
      default:            out_char_next = '0;
    endcase
  end

  // Status to the controller.
  assign status.last        = last_reg;
  assign status.verdict     = verdict_next;
  assign status.cursor_done = (cursor == sym_len);
  assign status.out_free    = !out_valid || out_ready;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      char_position <= '0;
      match_flags   <= '1;
      overlong      <= 1'b0;
      write_slot    <= '0;
      fill_count    <= '0;
      cursor        <= '0;
      out_valid     <= 1'b0;
      for (int s = 0; s < SLOTS; s++) begin
        slot_len[s] <= '0;
      end
    end else begin
      if (cmd.compare) begin
        if (in_range) begin
          match_flags <= flags_cmp;
        end else begin
          overlong <= 1'b1;
        end
        if (char_position < dvc_pkg::POS_MAX) begin
          char_position <= char_position + POS_W'(1);
        end
      end
      if (cmd.decide) begin
        char_position <= '0;
        match_flags   <= '1;
        overlong      <= 1'b0;
        cursor        <= '0;
      end
      if (cmd.cursor_inc) begin
        cursor <= cursor + POS_W'(1);
      end
      if (cmd.store_done) begin
        write_slot <= (write_slot == SW'(SLOTS - 1)) ? '0 : write_slot + SW'(1);
        if (fill_count < FW'(SLOTS)) begin
          fill_count <= fill_count + FW'(1);
        end
        if (sym_len > slot_len[write_slot]) begin
          slot_len[write_slot] <= sym_len;
        end
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      ch_reg       <= symbol_char;
      last_reg     <= char_last;
      complete_reg <= symbol_complete;
    end
    if (cmd.decide) begin
      verdict_reg <= verdict_next;
      sym_len     <= char_position;
    end
    if (cmd.out_load) begin
      out_char      <= out_char_next;
      out_last      <= (cmd.out_sel == dvc_pkg::OUT_BLANK) ||
                       (cmd.out_sel == dvc_pkg::OUT_LF);
      verdict       <= verdict_reg;
      symbol_length <= sym_len;
    end
  end

  `DVC_ASSERT_IMPL(a_fill_bound, 1'b1, fill_count <= FW'(SLOTS))
  `DVC_ASSERT_IMPL(a_copy_in_range, cmd.hist_write, cursor < sym_len)
  `DVC_ASSERT_IMPL(a_confirm_ends_lf, out_valid && out_last && (verdict == dvc_pkg::VERDICT_CONFIRMED), out_char == dvc_pkg::CHAR_LF)
  `DVC_ASSERT_IMPL(a_single_result, out_valid && (verdict != dvc_pkg::VERDICT_CONFIRMED), out_last && (out_char == '0))
  `DVC_ASSERT_NEXT(a_symbol_cleared, cmd.decide, (char_position == '0) && !overlong && (match_flags == '1))

endmodule

`default_nettype wire

// File: src/decode_vote_confirm.sv
// Symbol vote confirmation: a decoded symbol arrives one character per transaction and is
// compared as it arrives against SLOTS history slots held in per-slot RAMs. Each character
// is accepted, then compared against one registered read of every slot RAM. After the
// final character a decide state settles the outcome. A stored symbol is copied from the
// staging RAM into its ring slot through a read state and a write state per character,
// then one result transaction reports it; partial and overlong symbols go straight to
// one result. A confirmed symbol is sent character by character through a read state and
// an emit state, then CR and LF, paced by out_ready. No new character is accepted until
// the current symbol's work is done, but the last result may still wait in the output
// register. History appears all zero after reset with no clearing pass, since each slot
// tracks its written length. Depends on dvc_pkg, dvc_ctrl and dvc_datapath.
`default_nettype none

module decode_vote_confirm #(
  parameter int SLOTS            = 8,
  parameter int MAX_SYMBOL_CHARS = 32
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] symbol_char,
  input  logic       char_last,
  input  logic       symbol_complete,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_char,
  output logic       out_last,
  output logic [1:0] verdict,
  output logic [5:0] symbol_length
);

  dvc_pkg::dp_cmd_t    cmd;
  dvc_pkg::dp_status_t status;

  // Sequencing of each character and each ended symbol.
  dvc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // Storage, compare, vote and output register.
  dvc_datapath #(
    .SLOTS            (SLOTS),
    .MAX_SYMBOL_CHARS (MAX_SYMBOL_CHARS)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .symbol_char     (symbol_char),
    .char_last       (char_last),
    .symbol_complete (symbol_complete),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_char        (out_char),
    .out_last        (out_last),
    .verdict         (verdict),
    .symbol_length   (symbol_length)
  );

endmodule

`default_nettype wire
